// File: design/cisf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cisf_pkg
// Shared types, constants and helpers of the case-insensitive substring
// finder.
// ----------------------------------------------------------------------------
package cisf_pkg;

  localparam int unsigned MaxPattern = 8;
  localparam int unsigned PatIdxW    = $clog2(MaxPattern);
  localparam int unsigned ProgW      = 4;
  localparam int unsigned PosW       = 16;
  localparam int unsigned CountW     = 16;
  localparam int unsigned AddrW      = 5;
  localparam int unsigned DataW      = 64;

  localparam logic [ProgW-1:0]  MaxPatternLen = ProgW'(MaxPattern);
  localparam logic [PosW-1:0]   PosMax        = {PosW{1'b1}};
  localparam logic [CountW-1:0] CountMax      = {CountW{1'b1}};

  typedef enum logic [1:0] {
    REG_PATTERN_BYTES  = 2'd0,
    REG_PATTERN_LENGTH = 2'd1,
    REG_START_OFFSET   = 2'd2,
    REG_MAX_MATCHES    = 2'd3
  } cisf_reg_e;

  typedef struct packed {
    logic [MaxPattern-1:0][7:0] pattern_bytes;
    logic [3:0]                 pattern_length;
    logic [15:0]                start_offset;
    logic [15:0]                max_matches;
  } cisf_cfg_t;

  typedef struct packed {
    logic [15:0] match_position;
    logic        is_match;
    logic        limit_reached;
    logic        text_too_long;
    logic        last_result;
  } cisf_result_t;

  // fold A to Z onto lower case, leave every other byte alone
  function automatic logic [7:0] fold(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

// File: design/cisf_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cisf_core
// Per-text search state and the step that takes one byte,
// updates progress, position and match count, and forms the result.
// ----------------------------------------------------------------------------
module cisf_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cisf_pkg::cisf_cfg_t   cfg_i,
  input  logic                  step_i,
  input  logic [7:0]            text_byte_i,
  input  logic                  end_of_text_i,
  output logic                  emit_o,
  output cisf_pkg::cisf_result_t result_o
);
  import cisf_pkg::*;

  logic [ProgW-1:0]  prog_q, prog_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [CountW-1:0] found_cnt_q, found_cnt_d;
  logic              stopped_q, stopped_d;
  logic              ovf_q, ovf_d;

  logic [7:0]        byte_f;
  logic [7:0]        pat_cur;
  logic [7:0]        pat_first;
  logic [ProgW-1:0]  len_eff;
  logic              active;
  logic              found;
  logic              limit;
  logic [PosW-1:0]   start_pos;

  always_comb begin
    byte_f    = fold(text_byte_i);
    pat_cur   = fold(cfg_i.pattern_bytes[prog_q[PatIdxW-1:0]]);
    pat_first = fold(cfg_i.pattern_bytes[0]);

    priority if (cfg_i.pattern_length == '0) begin
      len_eff = ProgW'(1);
    end else if (cfg_i.pattern_length > MaxPatternLen) begin
      len_eff = MaxPatternLen;
    end else begin
      len_eff = cfg_i.pattern_length;
    end

    active = !stopped_q && (pos_q >= cfg_i.start_offset);

    prog_d = prog_q;
    if (active) begin
      // restart rule: fall back to the first pattern byte only
      priority if (prog_q < len_eff && byte_f == pat_cur) begin
        prog_d = prog_q + ProgW'(1);
      end else if (byte_f == pat_first) begin
        prog_d = ProgW'(1);
      end else begin
        prog_d = '0;
      end
    end

    found     = active && (prog_d == len_eff);
    start_pos = pos_q - PosW'(len_eff - ProgW'(1));

    found_cnt_d = found_cnt_q;
    if (found && found_cnt_q != CountMax) begin
      found_cnt_d = found_cnt_q + CountW'(1);
    end
    limit     = (cfg_i.max_matches != '0) && (found_cnt_d == cfg_i.max_matches);
    stopped_d = stopped_q || (found && limit);

    if (pos_q == PosMax) begin
      pos_d = PosMax;
      ovf_d = 1'b1;
    end else begin
      pos_d = pos_q + PosW'(1);
      ovf_d = ovf_q;
    end
  end

  always_comb begin
    emit_o                  = found || end_of_text_i;
    result_o.match_position = found ? start_pos[15:0] : 16'd0;
    result_o.is_match       = found;
    result_o.limit_reached  = limit;
    result_o.text_too_long  = ovf_d;
    result_o.last_result    = end_of_text_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_q      <= '0;
      pos_q       <= '0;
      found_cnt_q <= '0;
      stopped_q   <= 1'b0;
      ovf_q       <= 1'b0;
    end else if (step_i) begin
      if (end_of_text_i) begin
        // text closed, next byte starts a fresh text at position 0
        prog_q      <= '0;
        pos_q       <= '0;
        found_cnt_q <= '0;
        stopped_q   <= 1'b0;
        ovf_q       <= 1'b0;
      end else begin
        prog_q      <= prog_d;
        pos_q       <= pos_d;
        found_cnt_q <= found_cnt_d;
        stopped_q   <= stopped_d;
        ovf_q       <= ovf_d;
      end
    end
  end

endmodule

// File: design/case_insensitive_substring_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// case_insensitive_substring_finder
// A result is registered in the output register, or waits in the skid stage.
// Throughput: one text byte per cycle; a two-entry output register and skid
// stage keep in_ready_o high unless two results wait on the consumer.
// Reset clears search state and sets the registers to their defaults.
// ----------------------------------------------------------------------------
module case_insensitive_substring_finder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // text channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 text_byte_i,
  input  logic                       end_of_text_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [15:0]                match_position_o,
  output logic                       is_match_o,
  output logic                       limit_reached_o,
  output logic                       text_too_long_o,
  output logic                       last_result_o,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cisf_pkg::AddrW-1:0] paddr,
  input  logic [cisf_pkg::DataW-1:0] pwdata,
  output logic [cisf_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import cisf_pkg::*;

  cisf_cfg_t    cfg_q;
  cisf_reg_e    reg_sel;
  logic         cfg_wr;

  logic         step;
  logic         emit;
  cisf_result_t res;

  cisf_result_t main_q, main_d;
  cisf_result_t skid_q, skid_d;
  logic         main_valid_q, main_valid_d;
  logic         skid_valid_q, skid_valid_d;
  logic         push;
  logic         pop;

  // ---------------- register port ----------------
  assign pready  = 1'b1;
  assign reg_sel = cisf_reg_e'(paddr[AddrW-1:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_bytes  <= '0;
      cfg_q.pattern_length <= 4'd1;
      cfg_q.start_offset   <= '0;
      cfg_q.max_matches    <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_PATTERN_BYTES:  cfg_q.pattern_bytes  <= pwdata;
        REG_PATTERN_LENGTH: cfg_q.pattern_length <= pwdata[3:0];
        REG_START_OFFSET:   cfg_q.start_offset   <= pwdata[15:0];
        REG_MAX_MATCHES:    cfg_q.max_matches    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PATTERN_BYTES:  prdata = cfg_q.pattern_bytes;
      REG_PATTERN_LENGTH: prdata = DataW'(cfg_q.pattern_length);
      REG_START_OFFSET:   prdata = DataW'(cfg_q.start_offset);
      REG_MAX_MATCHES:    prdata = DataW'(cfg_q.max_matches);
      default:            prdata = '0;
    endcase
  end

  // ---------------- search step ----------------
  assign in_ready_o = !skid_valid_q;
  assign step       = in_valid_i && in_ready_o;

  cisf_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .step_i        (step),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .emit_o        (emit),
    .result_o      (res)
  );

  // ---------------- output register and skid ----------------
  assign push = step && emit;
  assign pop  = main_valid_q && out_ready_i;

  always_comb begin
    main_d       = main_q;
    skid_d       = skid_q;
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    if (pop || !main_valid_q) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_d       = res;
        skid_valid_d = push;
      end else begin
        main_d       = res;
        main_valid_d = push;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      // output stalled, park the new transaction in the skid stage
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign out_valid_o      = main_valid_q;
  assign match_position_o = main_q.match_position;
  assign is_match_o       = main_q.is_match;
  assign limit_reached_o  = main_q.limit_reached;
  assign text_too_long_o  = main_q.text_too_long;
  assign last_result_o    = main_q.last_result;

endmodule

// File: design/cisf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cisf_checker
// Port-level checks on the substring finder's result channel.
// ----------------------------------------------------------------------------
module cisf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] match_position_o,
  input logic        is_match_o,
  input logic        last_result_o
);

  // a stalled transaction keeps its payload
  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_ready_i |=>
        out_valid_o && $stable(match_position_o) && $stable(is_match_o)
        && $stable(last_result_o);
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result changed while stalled");

  // every result reports a match or closes a text
  property p_result_reason;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> is_match_o || last_result_o;
  endproperty
  a_result_reason: assert property (p_result_reason) else $error("empty result");

  // position is zero when no match is reported
  property p_pos_zero;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !is_match_o |-> match_position_o == 16'd0;
  endproperty
  a_pos_zero: assert property (p_pos_zero) else $error("position without match");

  // input is held back only while both output slots are full
  property p_ready_backpressure;
    @(posedge clk_i) disable iff (!rst_ni)
      !in_ready_o |-> out_valid_o;
  endproperty
  a_ready_backpressure: assert property (p_ready_backpressure)
    else $error("input stalled with empty output");

endmodule

bind case_insensitive_substring_finder cisf_checker u_cisf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .match_position_o (match_position_o),
  .is_match_o       (is_match_o),
  .last_result_o    (last_result_o)
);
